// ----- src/mcdb_pkg.sv -----
// ----------------------------------------------------------------------------
// mcdb_pkg
// Shared types and constants for the depth-first maze carver: controller
// commands, datapath status, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package mcdb_pkg;

  localparam int DEF_MAX_COLS  = 32;
  localparam int DEF_MAX_ROWS  = 32;
  localparam int DEF_RAND_BITS = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW = 2'd3;

  localparam logic [5:0] GRID_COLS_RST  = 6'd8;
  localparam logic [5:0] GRID_ROWS_RST  = 6'd8;
  localparam logic [4:0] ORIGIN_COL_RST = 5'd0;
  localparam logic [4:0] ORIGIN_ROW_RST = 5'd0;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic start;     // restart item accepted: latch grid, start cell
    logic step;      // carve item accepted: capture random word, read row above
    logic clear;     // write one row of the seen map during the clear sweep
    logic rd_up;     // read row above the current cell
    logic rd_dn;     // capture row above, read row below
    logic rd_mid;    // capture row below, read current row
    logic eval;      // decide: carve, pop or stop
    logic pop_load;  // load current cell from popped stack entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic clr_last;
    logic has_cand;
    logic stack_empty;
    logic res_pending;
  } sts_t;

endpackage

// ----- src/mcdb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcdb_ctrl
// Sequencer for the maze carver: input handshake, seen-map clear sweep,
// neighbour row reads, carve decision and stack backtracking.
// ----------------------------------------------------------------------------
module mcdb_ctrl
  import mcdb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic restart,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_UP,
    S_RD_DN,
    S_RD_MID,
    S_EVAL,
    S_POP
  } state_t;

  state_t state;
  logic   acc;

  // a held result blocks the input only while it cannot move to the output register
  assign in_stall = (state != S_IDLE) || sts.res_pending;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd          = '0;
    cmd.start    = acc && restart;
    cmd.step     = acc && !restart;
    cmd.clear    = (state == S_CLEAR);
    cmd.rd_up    = (state == S_RD_UP);
    cmd.rd_dn    = (state == S_RD_DN);
    cmd.rd_mid   = (state == S_RD_MID);
    cmd.eval     = (state == S_EVAL);
    cmd.pop_load = (state == S_POP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc && restart) begin
            state <= S_CLEAR;
          end else if (acc && sts.active) begin
            state <= S_RD_DN;
          end
        end
        S_CLEAR: begin
          if (sts.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_RD_UP:  state <= S_RD_DN;
        S_RD_DN:  state <= S_RD_MID;
        S_RD_MID: state <= S_EVAL;
        S_EVAL: begin
          if (sts.has_cand || sts.stack_empty) begin
            state <= S_IDLE;
          end else begin
            state <= S_POP;
          end
        end
        S_POP:   state <= S_RD_UP;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mcdb_dpath.sv -----
// ----------------------------------------------------------------------------
// mcdb_dpath
// Datapath for the maze carver: configuration registers, seen map stored
// one grid row per word, path stack memory, neighbour selection and the
// result skid and output registers.
// ----------------------------------------------------------------------------
module mcdb_dpath
  import mcdb_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int RAND_BITS = DEF_RAND_BITS
)(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [14:0]           random_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            from_col,
  output logic [4:0]            from_row,
  output logic [1:0]            carve_dir,
  output logic                  maze_done
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COLN_W = $clog2(MAX_COLS + 1);
  localparam int ROWN_W = $clog2(MAX_ROWS + 1);
  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int SP_W   = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int STK_W  = ROW_W + COL_W;
  localparam int PROD_W = COLN_W + ROWN_W;
  localparam logic [31:0] RAND_MASK = 32'((64'd1 << RAND_BITS) - 64'd1);

  // remainder by three: 4^k is 1 mod 3, so fold base-4 digits
  function automatic logic [1:0] mod3(input logic [31:0] v);
    logic [5:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      s = s + 6'(v[2*i +: 2]);
    end
    t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  // direction of the k-th candidate, counted in left, right, up, down order
  function automatic logic [1:0] nth_cand(input logic [3:0] cand, input logic [1:0] k);
    logic [1:0] cnt;
    logic [1:0] d;
    cnt = '0;
    d   = DIR_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (cnt == k) begin
          d = 2'(i);
        end
        cnt = cnt + 2'd1;
      end
    end
    return d;
  endfunction

  // configuration
  logic [5:0] grid_cols, grid_rows;
  logic [4:0] origin_col, origin_row;

  // walk state
  logic [COLN_W-1:0] live_cols;
  logic [ROWN_W-1:0] live_rows;
  logic [COL_W-1:0]  here_col;
  logic [ROW_W-1:0]  here_row;
  logic [CNT_W-1:0]  stack_depth;
  logic [CNT_W-1:0]  seen_count;
  logic [CNT_W-1:0]  total_cells;
  logic              active;
  logic [ROW_W-1:0]  clr_cnt;
  logic [1:0]        rw_lo;
  logic [1:0]        rw_m3;

  // memories
  logic [MAX_COLS-1:0] seen_mem [MAX_ROWS];
  logic [STK_W-1:0]    stack_mem [CELLS];
  logic [MAX_COLS-1:0] rd_data;
  logic [STK_W-1:0]    stk_q;
  logic [MAX_COLS-1:0] row_up, row_dn;

  // result skid register
  logic       res_pending;
  logic [4:0] res_col, res_row;
  logic [1:0] res_dir;
  logic       res_done;

  // combinational
  logic [31:0]         lc32, lr32, rw32;
  logic [ROW_W-1:0]    r_m1, r_p1, rd_row, wr_row;
  logic [COL_W-1:0]    c_m1, c_p1, nc;
  logic [ROW_W-1:0]    nr;
  logic                has_l, has_r, has_u, has_d;
  logic [3:0]          cand;
  logic [2:0]          n_cand;
  logic [1:0]          pick, dir;
  logic [MAX_COLS-1:0] row_nr, wr_word;
  logic                seen_we, carve, pop, push;
  logic [SP_W-1:0]     stk_rd_addr;
  logic [CNT_W-1:0]    seen_next;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    if (grid_cols == '0) begin
      lc32 = 32'd1;
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      lc32 = 32'(MAX_COLS);
    end else begin
      lc32 = 32'(grid_cols);
    end
    if (grid_rows == '0) begin
      lr32 = 32'd1;
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      lr32 = 32'(MAX_ROWS);
    end else begin
      lr32 = 32'(grid_rows);
    end
  end

  assign rw32 = 32'(random_word) & RAND_MASK;

  // neighbour indexes, held in range at the grid edge (masked by bounds)
  assign c_m1 = (here_col == '0) ? here_col : here_col - COL_W'(1);
  assign c_p1 = (here_col == COL_W'(MAX_COLS - 1)) ? here_col : here_col + COL_W'(1);
  assign r_m1 = (here_row == '0) ? here_row : here_row - ROW_W'(1);
  assign r_p1 = (here_row == ROW_W'(MAX_ROWS - 1)) ? here_row : here_row + ROW_W'(1);

  assign has_l = (here_col != '0);
  assign has_r = (COLN_W'(here_col) + COLN_W'(1)) < live_cols;
  assign has_u = (here_row != '0);
  assign has_d = (ROWN_W'(here_row) + ROWN_W'(1)) < live_rows;

  // in the decide cycle the current row is on the memory read port
  assign cand[0] = has_l && !rd_data[c_m1];
  assign cand[1] = has_r && !rd_data[c_p1];
  assign cand[2] = has_u && !row_up[here_col];
  assign cand[3] = has_d && !row_dn[here_col];

  assign n_cand = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

  always_comb begin
    case (n_cand)
      3'd2:    pick = {1'b0, rw_lo[0]};
      3'd3:    pick = rw_m3;
      3'd4:    pick = rw_lo;
      default: pick = 2'd0;
    endcase
  end

  assign dir = nth_cand(cand, pick);

  always_comb begin
    nc     = here_col;
    nr     = here_row;
    row_nr = rd_data;
    case (dir)
      DIR_LEFT:  nc = c_m1;
      DIR_RIGHT: nc = c_p1;
      DIR_UP: begin
        nr     = r_m1;
        row_nr = row_up;
      end
      default: begin
        nr     = r_p1;
        row_nr = row_dn;
      end
    endcase
  end

  assign carve     = cmd.eval && (n_cand != '0);
  assign pop       = cmd.eval && (n_cand == '0) && (stack_depth != '0);
  assign push      = carve && (stack_depth < CNT_W'(CELLS));
  assign seen_next = seen_count + CNT_W'(1);
  assign prod      = PROD_W'(live_cols) * PROD_W'(live_rows);

  always_comb begin
    if (cmd.step || cmd.rd_up) begin
      rd_row = r_m1;
    end else if (cmd.rd_dn) begin
      rd_row = r_p1;
    end else begin
      rd_row = here_row;
    end
  end

  always_comb begin
    seen_we = cmd.clear || carve;
    if (cmd.clear) begin
      wr_row  = clr_cnt;
      wr_word = (clr_cnt == here_row) ? (MAX_COLS'(1) << here_col) : '0;
    end else begin
      wr_row  = nr;
      wr_word = row_nr | (MAX_COLS'(1) << nc);
    end
  end

  assign stk_rd_addr = (stack_depth == '0) ? '0 : SP_W'(stack_depth - CNT_W'(1));

  always_ff @(posedge clk) begin
    rd_data <= seen_mem[rd_row];
    if (seen_we) begin
      seen_mem[wr_row] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    stk_q <= stack_mem[stk_rd_addr];
    if (push) begin
      stack_mem[SP_W'(stack_depth)] <= {here_row, here_col};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_dn) begin
      row_up <= rd_data;
    end
    if (cmd.rd_mid) begin
      row_dn <= rd_data;
    end
    if (cmd.step) begin
      rw_lo <= rw32[1:0];
      rw_m3 <= mod3(rw32);
    end
    if (cmd.clear) begin
      total_cells <= CNT_W'(prod);
    end
    if (carve) begin
      res_col  <= 5'(here_col);
      res_row  <= 5'(here_row);
      res_dir  <= dir;
      res_done <= (seen_next >= total_cells);
    end
    if (res_pending && (!out_valid || !out_stall)) begin
      from_col  <= res_col;
      from_row  <= res_row;
      carve_dir <= res_dir;
      maze_done <= res_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols   <= GRID_COLS_RST;
      grid_rows   <= GRID_ROWS_RST;
      origin_col  <= ORIGIN_COL_RST;
      origin_row  <= ORIGIN_ROW_RST;
      live_cols   <= COLN_W'(1);
      live_rows   <= ROWN_W'(1);
      here_col    <= '0;
      here_row    <= '0;
      stack_depth <= '0;
      seen_count  <= '0;
      active      <= 1'b0;
      clr_cnt     <= '0;
      res_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_COLS:  grid_cols  <= cfg_data;
          CFG_GRID_ROWS:  grid_rows  <= cfg_data;
          CFG_ORIGIN_COL: origin_col <= cfg_data[4:0];
          CFG_ORIGIN_ROW: origin_row <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (cmd.start) begin
        live_cols   <= COLN_W'(lc32);
        live_rows   <= ROWN_W'(lr32);
        here_col    <= (32'(origin_col) < lc32) ? COL_W'(origin_col) : COL_W'(lc32 - 32'd1);
        here_row    <= (32'(origin_row) < lr32) ? ROW_W'(origin_row) : ROW_W'(lr32 - 32'd1);
        stack_depth <= '0;
        seen_count  <= CNT_W'(1);
        active      <= (lc32 > 32'd1) || (lr32 > 32'd1);
        clr_cnt     <= '0;
      end

      if (cmd.clear) begin
        clr_cnt <= clr_cnt + ROW_W'(1);
      end

      if (carve) begin
        here_col   <= nc;
        here_row   <= nr;
        seen_count <= seen_next;
        if (push) begin
          stack_depth <= stack_depth + CNT_W'(1);
        end
        if (seen_next >= total_cells) begin
          active <= 1'b0;
        end
      end else if (pop) begin
        stack_depth <= stack_depth - CNT_W'(1);
      end else if (cmd.eval) begin
        // dead end with nothing left to backtrack to
        active <= 1'b0;
      end

      if (cmd.pop_load) begin
        here_col <= stk_q[COL_W-1:0];
        here_row <= stk_q[STK_W-1:COL_W];
      end

      // output register drains, then the skid register refills it
      if (res_pending && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (carve) begin
        res_pending <= 1'b1;
      end else if (res_pending && (!out_valid || !out_stall)) begin
        res_pending <= 1'b0;
      end
    end
  end

  always_comb begin
    sts             = '0;
    sts.active      = active;
    sts.clr_last    = (clr_cnt == ROW_W'(MAX_ROWS - 1));
    sts.has_cand    = (n_cand != '0);
    sts.stack_empty = (stack_depth == '0);
    // skid result that cannot move on this cycle
    sts.res_pending = res_pending && out_valid && out_stall;
  end

`ifndef SYNTHESIS
  a_depth_below_seen: assert property (@(posedge clk) disable iff (rst)
    active |-> (stack_depth < seen_count))
    else $error("path stack deeper than visited cell count");

  a_here_in_grid: assert property (@(posedge clk) disable iff (rst)
    active |-> ((COLN_W'(here_col) < live_cols) && (ROWN_W'(here_row) < live_rows)))
    else $error("current cell outside latched grid");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    carve |-> !res_pending)
    else $error("carve while skid register still holds a result");

  a_pop_reloads: assert property (@(posedge clk) disable iff (rst)
    pop |=> cmd.pop_load)
    else $error("stack pop not followed by current cell reload");
`endif

endmodule

// ----- src/maze_carver_dfs_backtracker_core.sv -----
// ----------------------------------------------------------------------------
// maze_carver_dfs_backtracker_core
// Randomized depth-first maze carver over a grid of up to MAX_COLS by
// MAX_ROWS cells; emits at most one carved passage per step item.
// ----------------------------------------------------------------------------
// a carving step item reads the rows above and below and the current row,
//   then decides; each backtrack pop adds a stack reload and three row reads
// no new item is accepted until the current one is finished
// a restart item is followed by a seen-map clear sweep of MAX_ROWS rows,
//   one row per cycle, during which no item is accepted
// reset: registers take their reset values, no maze is active until restart
module maze_carver_dfs_backtracker_core
  import mcdb_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int RAND_BITS = DEF_RAND_BITS
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  restart,
  input  logic [14:0]           random_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            from_col,
  output logic [4:0]            from_row,
  output logic [1:0]            carve_dir,
  output logic                  maze_done
);

  cmd_t cmd;
  sts_t sts;

  mcdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (restart),
    .cmd      (cmd),
    .sts      (sts)
  );

  mcdb_dpath #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .RAND_BITS (RAND_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .from_col    (from_col),
    .from_row    (from_row),
    .carve_dir   (carve_dir),
    .maze_done   (maze_done)
  );

endmodule
